// ===== hw/rtl/ips_pkg.sv =====
package ips_pkg;

  // default geometry
  localparam int LANES_DEF     = 8;
  localparam int DATA_BITS_DEF = 32;

  // width of the lane count field
  localparam int COUNT_BITS = 4;

  // control that travels alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
  } ips_ctl_t;

endpackage

// ===== hw/rtl/inclusive_prefix_sum_lanes_top.sv =====
// pipeline: 2*log2(P)-1 scan-tree levels, P = LANES rounded up to a power of two,
//   one register stage per level, plus the carry-add output stage
// throughput: one group per cycle, stalls only when out_tready holds back a full pipe
// reset (rst_n low, synchronous): all stage valid flags and the running total clear
module inclusive_prefix_sum_lanes_top import ips_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int IN_W     = ((LANES * DATA_BITS + COUNT_BITS + 7) / 8) * 8,
  localparam int OUT_W    = ((LANES * DATA_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input group
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // value_0 .. value_{LANES-1}, lane_count, zero pad
  input  logic              in_tlast,   // end_of_vector
  // prefix sums
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // sum_0 .. sum_{LANES-1}, zero pad
  output logic              out_tlast   // result_last
);

  // tree width: lanes padded to a power of two, padding lanes held at zero
  localparam int LOG    = $clog2(LANES);
  localparam int P      = 1 << LOG;
  // up-sweep has LOG levels, down-sweep LOG-1 levels
  localparam int NSTAGE = 2 * LOG - 1;

  logic [COUNT_BITS-1:0]          in_cnt;
  logic [P-1:0][DATA_BITS-1:0]    lane_in;

  ips_ctl_t                       stg_ctl   [NSTAGE+1];
  logic [P-1:0][DATA_BITS-1:0]    stg_data  [NSTAGE+1];
  logic                           stg_ready [NSTAGE+1];

  assign in_cnt = in_tdata[LANES*DATA_BITS +: COUNT_BITS];

  // lanes at or above lane_count enter the tree as zero
  for (genvar k = 0; k < P; k++) begin : g_mask
    if ((k < LANES) && (k < (1 << COUNT_BITS))) begin : g_live
      assign lane_in[k] = (COUNT_BITS'(k) < in_cnt) ?
                          in_tdata[k*DATA_BITS +: DATA_BITS] : '0;
    end else begin : g_dead
      assign lane_in[k] = '0;
    end
  end

  assign stg_ctl[0]  = '{valid: in_tvalid, last: in_tlast};
  assign stg_data[0] = lane_in;
  assign in_tready   = stg_ready[0];

  // work-efficient scan: up-sweep builds subtree sums, down-sweep spreads them
  for (genvar s = 0; s < NSTAGE; s++) begin : g_level
    localparam bit IS_UP  = (s < LOG);
    localparam int STRIDE = IS_UP ? (1 << s) : (1 << (2 * LOG - 2 - s));

    ips_scan_level #(
      .P         (P),
      .DATA_BITS (DATA_BITS),
      .STRIDE    (STRIDE),
      .UP        (IS_UP)
    ) u_level (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (stg_ctl[s]),
      .up_data  (stg_data[s]),
      .up_ready (stg_ready[s]),
      .dn_ctl   (stg_ctl[s+1]),
      .dn_data  (stg_data[s+1]),
      .dn_ready (stg_ready[s+1])
    );
  end

  // running total added to every lane, output register toward the sink
  ips_carry_merge #(
    .LANES     (LANES),
    .P         (P),
    .DATA_BITS (DATA_BITS),
    .OUT_W     (OUT_W)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .tree_ctl   (stg_ctl[NSTAGE]),
    .tree_data  (stg_data[NSTAGE]),
    .tree_ready (stg_ready[NSTAGE]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/ips_scan_level.sv =====
module ips_scan_level import ips_pkg::*; #(
  parameter int P         = LANES_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int STRIDE    = 1,
  parameter bit UP        = 1'b1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ips_ctl_t                        up_ctl,
  input  logic [P-1:0][DATA_BITS-1:0]     up_data,
  output logic                            up_ready,
  output ips_ctl_t                        dn_ctl,
  output logic [P-1:0][DATA_BITS-1:0]     dn_data,
  input  logic                            dn_ready
);

  ips_ctl_t                        ctl_r;
  logic [P-1:0][DATA_BITS-1:0]     data_r;
  logic [P-1:0][DATA_BITS-1:0]     data_nxt;

  // one tree level: selected lanes add the partial sum STRIDE lanes below
  for (genvar k = 0; k < P; k++) begin : g_lane
    localparam bit UP_ADD = UP && (((k + 1) % (2 * STRIDE)) == 0);
    localparam bit DN_ADD = !UP && (k >= 2 * STRIDE) &&
                            (((k + 1 - STRIDE) % (2 * STRIDE)) == 0);
    if (UP_ADD) begin : g_up_add
      assign data_nxt[k] = up_data[k] + up_data[k-STRIDE];
    end else if (DN_ADD) begin : g_dn_add
      assign data_nxt[k] = up_data[k] + up_data[k-STRIDE];
    end else begin : g_pass
      assign data_nxt[k] = up_data[k];
    end
  end

  assign up_ready = !ctl_r.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_ctl  = ctl_r;
  assign dn_data = data_r;

endmodule

// ===== hw/rtl/ips_carry_merge.sv =====
module ips_carry_merge import ips_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int P         = LANES_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int OUT_W     = ((LANES * DATA_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ips_ctl_t                        tree_ctl,
  input  logic [P-1:0][DATA_BITS-1:0]     tree_data,
  output logic                            tree_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,
  output logic                            out_tlast
);

  logic [DATA_BITS-1:0]                total_r;
  logic [DATA_BITS-1:0]                total_nxt;
  logic                                out_valid_r;
  logic                                out_last_r;
  logic [LANES-1:0][DATA_BITS-1:0]     sum_r;
  logic [LANES-1:0][DATA_BITS-1:0]     sum_nxt;
  logic                                take;

  assign tree_ready = !out_valid_r || out_tready;
  assign take       = tree_ctl.valid && tree_ready;

  // add the carry from earlier groups into every lane
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      sum_nxt[k] = total_r + tree_data[k];
    end
    total_nxt = tree_ctl.last ? '0 : (total_r + tree_data[LANES-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (tree_ready) begin
        out_valid_r <= tree_ctl.valid;
      end
      if (take) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sum_r      <= sum_nxt;
      out_last_r <= tree_ctl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(sum_r);
  assign out_tlast  = out_last_r;

endmodule

// ===== dv/tb_inclusive_prefix_sum_lanes_top.sv =====
module tb_inclusive_prefix_sum_lanes_top;
  import ips_pkg::*;

  localparam int LANES     = LANES_DEF;
  localparam int DATA_BITS = DATA_BITS_DEF;
  localparam int VAL_BITS  = LANES * DATA_BITS;
  localparam int IN_W      = ((VAL_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int OUT_W     = ((VAL_BITS + 7) / 8) * 8;

  // random part stops once this many groups have been offered
  localparam int RANDOM_GROUPS = 700;
  // cycles with no transfer on either side before the run is declared hung
  localparam int IDLE_LIMIT    = 3000;
  // long receiver hold-off, well beyond the pipe depth so the input backs up
  localparam int HOLD_CYCLES   = 150;
  // settle time after the last result
  localparam int DRAIN_CYCLES  = 20;

  // one input group as it travels on in_tdata / in_tlast
  typedef struct packed {
    logic                              eov;
    logic [COUNT_BITS-1:0]             lane_count;
    logic [LANES-1:0][DATA_BITS-1:0]   lane_val;
  } lane_group_t;

  // one result: per-lane inclusive sums plus the end-of-vector copy
  typedef struct packed {
    logic                              last;
    logic [LANES-1:0][DATA_BITS-1:0]   sum;
  } prefix_sums_t;

  // directed row: lane k carries base + k*step; typed rows carry a hand-written answer
  typedef struct packed {
    logic                              typed;
    logic                              eov;
    logic [COUNT_BITS-1:0]             cnt;
    logic [DATA_BITS-1:0]              base;
    logic [DATA_BITS-1:0]              step;
    logic [LANES-1:0][DATA_BITS-1:0]   exp_sum;
  } dir_row_t;

  localparam int NUM_DIRECTED = 18;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // value_0 .. value_7, lane_count, zero pad
  logic             in_tlast   = 1'b0; // end_of_vector
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // sum_0 .. sum_7
  logic             out_tlast;         // result_last

  // predictor state: wrapped total of the groups of the current vector
  logic [DATA_BITS-1:0] vector_carry = '0;
  prefix_sums_t         expected_sums_q [$];
  int                   mismatch_count = 0;
  int                   sums_checked   = 0;
  int                   burst_left     = 0;
  int                   idle_cycles    = 0;
  int                   rx_cycle       = 0;
  int                   hold_left      = 0;
  bit                   hold_done      = 1'b0;
  dir_row_t             directed_rows [NUM_DIRECTED];

  inclusive_prefix_sum_lanes_top #(
    .LANES     (LANES),
    .DATA_BITS (DATA_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // serial scan over the lanes; lanes at or above the (saturated) count add nothing,
  // and the carry clears once the end-of-vector group has produced its sums
  function automatic prefix_sums_t scan_group(input lane_group_t g,
                                              inout logic [DATA_BITS-1:0] carry);
    int           valid_lanes;
    prefix_sums_t r;
    valid_lanes = (g.lane_count > LANES) ? LANES : int'(g.lane_count);
    for (int k = 0; k < LANES; k++) begin
      if (k < valid_lanes) carry = carry + g.lane_val[k];
      r.sum[k] = carry;
    end
    r.last = g.eov;
    if (g.eov) carry = '0;
    return r;
  endfunction

  // offer one group, wait for its transfer, queue its expected sums, then maybe idle
  task automatic send_group(input lane_group_t g, input bit has_typed,
                            input prefix_sums_t typed_sums);
    prefix_sums_t predicted;
    int           gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({g.lane_count, g.lane_val});
    in_tlast  <= g.eov;
    do @(posedge clk); while (!in_tready);
    // the predictor runs on every group so its carry stays in step
    predicted = scan_group(g, vector_carry);
    expected_sums_q = {expected_sums_q, (has_typed ? typed_sums : predicted)};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // end of burst: drop valid for a random gap, then pick the next burst length
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(0, 15);
    end
  endtask

  // stimulus: directed table first, then random vectors
  initial begin
    lane_group_t  g;
    prefix_sums_t typed;
    int           sent;
    int           vec_len;

    // typed rows are taken straight after a vector boundary, so the carry is zero
    directed_rows[0]  = '{typed: 1'b1, eov: 1'b1, cnt: 4'd8, base: 32'd1, step: 32'd0,
                          exp_sum: {32'd8, 32'd7, 32'd6, 32'd5,
                                    32'd4, 32'd3, 32'd2, 32'd1}};
    // invalid lanes repeat the last valid sum
    directed_rows[1]  = '{typed: 1'b1, eov: 1'b1, cnt: 4'd3, base: 32'd1, step: 32'd0,
                          exp_sum: {{6{32'd3}}, 32'd2, 32'd1}};
    // zero lane count: nothing is added
    directed_rows[2]  = '{typed: 1'b1, eov: 1'b1, cnt: 4'd0, base: 32'd5, step: 32'd0,
                          exp_sum: '0};
    // count above the lane total saturates
    directed_rows[3]  = '{typed: 1'b1, eov: 1'b1, cnt: 4'd15, base: 32'd1, step: 32'd0,
                          exp_sum: {32'd8, 32'd7, 32'd6, 32'd5,
                                    32'd4, 32'd3, 32'd2, 32'd1}};
    // most negative value wraps back to zero every second lane
    directed_rows[4]  = '{typed: 1'b1, eov: 1'b1, cnt: 4'd8, base: 32'h8000_0000,
                          step: 32'd0, exp_sum: {4{32'h0, 32'h8000_0000}}};
    directed_rows[5]  = '{typed: 1'b0, eov: 1'b1, cnt: 4'd8, base: 32'h7FFF_FFFF,
                          step: 32'd0, exp_sum: '0};
    // all minus one
    directed_rows[6]  = '{typed: 1'b1, eov: 1'b1, cnt: 4'd8, base: 32'hFFFF_FFFF,
                          step: 32'd0,
                          exp_sum: {32'hFFFF_FFF8, 32'hFFFF_FFF9, 32'hFFFF_FFFA,
                                    32'hFFFF_FFFB, 32'hFFFF_FFFC, 32'hFFFF_FFFD,
                                    32'hFFFF_FFFE, 32'hFFFF_FFFF}};
    // multi-group vector: carry runs across groups, zero count mid-vector, overflow
    directed_rows[7]  = '{typed: 1'b0, eov: 1'b0, cnt: 4'd8, base: 32'd10, step: 32'd1,
                          exp_sum: '0};
    directed_rows[8]  = '{typed: 1'b0, eov: 1'b0, cnt: 4'd0, base: 32'd100, step: 32'd0,
                          exp_sum: '0};
    directed_rows[9]  = '{typed: 1'b0, eov: 1'b0, cnt: 4'd5, base: 32'hAAAA_AAAA,
                          step: 32'h1111_1111, exp_sum: '0};
    directed_rows[10] = '{typed: 1'b0, eov: 1'b0, cnt: 4'd9, base: 32'h5555_5555,
                          step: 32'd0, exp_sum: '0};
    directed_rows[11] = '{typed: 1'b0, eov: 1'b0, cnt: 4'd8, base: 32'h7FFF_FFFF,
                          step: 32'd0, exp_sum: '0};
    directed_rows[12] = '{typed: 1'b0, eov: 1'b1, cnt: 4'd1, base: 32'd1, step: 32'd2,
                          exp_sum: '0};
    // carry must be clear after the end of the vector above
    directed_rows[13] = '{typed: 1'b1, eov: 1'b1, cnt: 4'd2, base: 32'd3, step: 32'd0,
                          exp_sum: {{7{32'd6}}, 32'd3}};
    directed_rows[14] = '{typed: 1'b0, eov: 1'b0, cnt: 4'd8, base: 32'd0, step: 32'd0,
                          exp_sum: '0};
    directed_rows[15] = '{typed: 1'b0, eov: 1'b0, cnt: 4'd12, base: 32'hFFFF_FFFF,
                          step: 32'hFFFF_FFFF, exp_sum: '0};
    directed_rows[16] = '{typed: 1'b0, eov: 1'b1, cnt: 4'd7, base: 32'h8000_0000,
                          step: 32'h8000_0000, exp_sum: '0};
    directed_rows[17] = '{typed: 1'b0, eov: 1'b1, cnt: 4'd4, base: 32'h1234_5678,
                          step: 32'h9ABC_DEF0, exp_sum: '0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      g.eov        = directed_rows[i].eov;
      g.lane_count = directed_rows[i].cnt;
      for (int k = 0; k < LANES; k++)
        g.lane_val[k] = directed_rows[i].base + DATA_BITS'(k) * directed_rows[i].step;
      typed.sum  = directed_rows[i].exp_sum;
      typed.last = directed_rows[i].eov;
      send_group(g, directed_rows[i].typed, typed);
    end

    // random vectors: mostly well-formed (full groups, short tail, end flag on the
    // final group) with some odd counts and stray end flags mixed in
    sent = 0;
    while (sent < RANDOM_GROUPS) begin
      vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      for (int j = 0; j < vec_len; j++) begin
        g.eov        = (j == vec_len - 1) || ($urandom_range(0, 29) == 0);
        g.lane_count = (j == vec_len - 1) ? COUNT_BITS'($urandom_range(1, LANES))
                                          : COUNT_BITS'(LANES);
        if ($urandom_range(0, 11) == 0) g.lane_count = COUNT_BITS'($urandom_range(0, 15));
        for (int k = 0; k < LANES; k++) begin
          case ($urandom_range(0, 9))
            0:       g.lane_val[k] = 32'h7FFF_FFFF;
            1:       g.lane_val[k] = 32'h8000_0000;
            2:       g.lane_val[k] = 32'hFFFF_FFFF;
            3:       g.lane_val[k] = 32'h0;
            4, 5:    g.lane_val[k] = DATA_BITS'($urandom_range(0, 200)) - 32'd100;
            default: g.lane_val[k] = $urandom();
          endcase
        end
        send_group(g, 1'b0, '0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (expected_sums_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: ready pattern rotates with rx_cycle[8:7] (always, coin flip, one in four,
  // mostly ready), plus one long hold-off once results are flowing
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && sums_checked >= 250) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom_range(0, 1));
        2'd2:    out_tready <= (rx_cycle[1:0] == 2'd0);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result check: each output transfer against the oldest expectation
  always @(posedge clk) begin
    prefix_sums_t want;
    prefix_sums_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.sum  = out_tdata[VAL_BITS-1:0];
      got.last = out_tlast;
      if (expected_sums_q.size() == 0) begin
        $display("%0t: unexpected result transfer, sums %h last %b",
                 $time, got.sum, got.last);
        mismatch_count++;
      end else begin
        want = expected_sums_q.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (got.sum[k] !== want.sum[k]) begin
            $display("%0t: sum_%0d expected %h actual %h",
                     $time, k, want.sum[k], got.sum[k]);
            mismatch_count++;
          end
        end
        if (got.last !== want.last) begin
          $display("%0t: result_last expected %b actual %b", $time, want.last, got.last);
          mismatch_count++;
        end
      end
      sums_checked <= sums_checked + 1;
    end
  end

  // watchdog: too many cycles without a transfer on either side means a hang
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
